// ===== rtl/isort_pkg.sv =====
`default_nettype none

package isort_pkg;

   localparam int VALUE_W = 32;

   // One input item
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   // One result item
   typedef struct packed {
      logic signed [VALUE_W-1:0] value_res;
      logic                      last_res;
      logic                      overflow;
   } rsp_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // Control broadcast to every cell of the chain
   typedef struct packed {
      logic insert;
      logic emit;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/isort_cell.sv =====
`default_nettype none

module isort_cell (
   input  wire logic                                  clock,
   input  wire isort_pkg::cell_ctrl_type              ctrl,
   input  wire logic                                  valid,
   input  wire logic signed [isort_pkg::VALUE_W-1:0]  new_value,
   input  wire logic signed [isort_pkg::VALUE_W-1:0]  prev_value,
   input  wire logic                                  prev_greater,
   input  wire logic signed [isort_pkg::VALUE_W-1:0]  next_value,
   output logic signed [isort_pkg::VALUE_W-1:0]       value,
   output logic                                       greater
);

   logic signed [isort_pkg::VALUE_W-1:0] value_ff;
   logic signed [isort_pkg::VALUE_W-1:0] value_in;

   // Flag an entry that must move up for the incoming value
   assign greater = valid && (new_value < value_ff);
   assign value   = value_ff;

   // Shift down while emitting; on insert take the lower neighbor,
   // the new value, or hold
   always_comb begin
      value_in = value_ff;
      if (ctrl.emit) begin
         value_in = next_value;
      end else if (ctrl.insert) begin
         if (prev_greater) begin
            value_in = prev_value;
         end else if (greater || !valid) begin
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

// ===== rtl/insertion_sorter.sv =====
`default_nettype none
// Channel   Ports                     Handshake
// input     req_data                  accepted when start && !busy
// result    rsp_data, rsp_strobe      valid while rsp_strobe high, taken at the next edge
//
// An item that is not marked last is inserted (dropped if the store is full);
// busy stays low. An item marked last is taken the same way, then the n
// stored values (n <= MAX_ITEMS) stream out back to back, busy high
// throughout: the cell chain shifts one place toward its bottom cell per cycle.
// Reset empties the store and clears the overflow flag.
// The receiver cannot stall; results are never held back.

module insertion_sorter #(
   parameter int MAX_ITEMS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire isort_pkg::req_type  req_data,
   output logic                     busy,
   output logic                     rsp_strobe,
   output isort_pkg::rsp_type       rsp_data
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   isort_pkg::state_type     state_ff;
   isort_pkg::state_type     state_in;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [CNT_W-1:0]         remain_ff;
   logic [CNT_W-1:0]         remain_in;
   logic                     dropped_ff;
   logic                     dropped_in;
   logic                     accept;
   logic                     full;
   logic [CNT_W-1:0]         count_after;
   isort_pkg::cell_ctrl_type ctrl;
   logic                     emitting;

   logic signed [isort_pkg::VALUE_W-1:0] cell_value [MAX_ITEMS];
   logic                                 cell_greater [MAX_ITEMS];

   assign accept      = start && !busy;
   assign full        = (count_ff == CNT_W'(MAX_ITEMS));
   assign count_after = full ? count_ff : count_ff + CNT_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         isort_pkg::ST_IDLE: begin
            if (accept && req_data.last) begin
               state_in = isort_pkg::ST_EMIT;
            end
         end
         isort_pkg::ST_EMIT: begin
            if (remain_ff == CNT_W'(1)) begin
               state_in = isort_pkg::ST_IDLE;
            end
         end
         default: state_in = isort_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      busy     = 1'b0;
      emitting = 1'b0;
      case (state_ff)
         isort_pkg::ST_IDLE: begin
            busy     = 1'b0;
            emitting = 1'b0;
         end
         isort_pkg::ST_EMIT: begin
            busy     = 1'b1;
            emitting = 1'b1;
         end
         default: begin
            busy     = 1'b0;
            emitting = 1'b0;
         end
      endcase
   end

   assign ctrl.insert = accept && !full;
   assign ctrl.emit   = emitting;

   // Track fill level, drop flag and results still to send
   always_comb begin
      count_in   = count_ff;
      remain_in  = remain_ff;
      dropped_in = dropped_ff;
      if (accept) begin
         count_in   = count_after;
         dropped_in = dropped_ff || full;
         if (req_data.last) begin
            remain_in = count_after;
         end
      end else if (emitting) begin
         remain_in = remain_ff - CNT_W'(1);
         if (remain_ff == CNT_W'(1)) begin
            count_in   = '0;
            dropped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= isort_pkg::ST_IDLE;
         count_ff   <= '0;
         remain_ff  <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         remain_ff  <= remain_in;
         dropped_ff <= dropped_in;
      end
   end

   // Cell chain: bottom cell holds the smallest value
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic signed [isort_pkg::VALUE_W-1:0] prev_value;
      logic                                 prev_greater;
      logic signed [isort_pkg::VALUE_W-1:0] next_value;

      if (i == 0) begin : g_bottom
         assign prev_value   = req_data.value;
         assign prev_greater = 1'b0;
      end else begin : g_mid
         assign prev_value   = cell_value[i-1];
         assign prev_greater = cell_greater[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_top
         assign next_value = cell_value[i];
      end else begin : g_below
         assign next_value = cell_value[i+1];
      end

      isort_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .valid        (CNT_W'(i) < count_ff),
         .new_value    (req_data.value),
         .prev_value   (prev_value),
         .prev_greater (prev_greater),
         .next_value   (next_value),
         .value        (cell_value[i]),
         .greater      (cell_greater[i])
      );
   end

   // Present the bottom cell while emitting
   assign rsp_strobe         = emitting;
   assign rsp_data.value_res = cell_value[0];
   assign rsp_data.last_res  = (remain_ff == CNT_W'(1));
   assign rsp_data.overflow  = dropped_ff;

endmodule

`default_nettype wire

// ===== rtl/isort_checker.sv =====
`default_nettype none

module isort_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire isort_pkg::req_type  req_data,
   input wire logic                busy,
   input wire logic                rsp_strobe,
   input wire isort_pkg::rsp_type  rsp_data
);

   // A result only appears while the block is busy
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // A last item starts emission on the next cycle
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.last) |=> rsp_strobe)
      else $error("no result after last item");

   // Results run back to back until the final one
   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last_res) |=> rsp_strobe)
      else $error("gap inside result burst");

   // The burst ends after the final result
   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_res) |=> !rsp_strobe)
      else $error("result after final item");

   // Overflow stays the same across one burst
   a_ovf_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last_res) |=> $stable(rsp_data.overflow))
      else $error("overflow changed within a burst");

endmodule

bind insertion_sorter isort_checker u_isort_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .req_data   (req_data),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
